FILE: src/lcdws_pkg.sv
// shared types, codes and timing constants for the lcd write sequencer
`timescale 1ns / 1ps
package lcdws_pkg;

  // request opcodes
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CHAR   = 3'd1;
  localparam logic [2:0] OP_CMD    = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_HEX    = 3'd4;
  localparam logic [2:0] OP_GLYPH  = 3'd5;

  // job kinds handed from front to back
  localparam logic [2:0] KIND_INIT  = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_CMD   = 3'd2;
  localparam logic [2:0] KIND_HEX   = 3'd3;
  localparam logic [2:0] KIND_GLYPH = 3'd4;

  // command bytes
  localparam logic [7:0] CMD_FUNC_2LINE = 8'h28;
  localparam logic [7:0] CMD_FUNC_1LINE = 8'h20;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h04;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_DDRAM      = 8'h80;
  localparam logic [7:0] CMD_CGRAM      = 8'h40;
  localparam logic [7:0] ROW_LINE_ODD   = 8'h40;
  localparam logic [7:0] ROW_FULL       = 8'h1F;
  localparam logic [7:0] ROW_BLANK      = 8'h00;

  localparam logic [3:0] NIB_INIT_8BIT  = 4'h3;
  localparam logic [3:0] NIB_INIT_4BIT  = 4'h2;

  localparam logic [5:0] LINE_WIDTH_RST = 6'd16;

  // strobe timing in microseconds
  localparam logic [16:0] T_SETUP         = 17'd40;
  localparam logic [16:0] T_POWERUP_SETUP = 17'd100040;
  localparam logic [12:0] T_HOLD          = 13'd40;
  localparam logic [12:0] T_DATA_LO       = 13'd80;
  localparam logic [12:0] T_CMD_LO        = 13'd1040;
  localparam logic [12:0] T_CMD_INIT_LO   = 13'd1080;
  localparam logic [12:0] T_CLEAR_LO      = 13'd3040;
  localparam logic [12:0] T_INIT_NIB      = 13'd5040;

  // last step index of each job kind
  localparam logic [4:0] LAST_INIT  = 5'd13;
  localparam logic [4:0] LAST_BYTE  = 5'd1;
  localparam logic [4:0] LAST_HEX   = 5'd3;
  localparam logic [4:0] LAST_GLYPH = 5'd17;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [2:0] glyph;
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib > 4'd9) ? ({4'd0, nib} + 8'd55) : ({4'd0, nib} + 8'd48);
  endfunction

endpackage

FILE: src/lcdws_front.sv
// front end: line width register and request classification into jobs
`timescale 1ns / 1ps
module lcdws_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [5:0]           cfg_wdata,
  input  logic                 req_valid,
  input  logic [2:0]           req_op,
  input  logic [7:0]           req_value,
  input  logic [1:0]           req_line,
  input  logic [5:0]           req_column,
  input  logic [2:0]           req_glyph,
  output logic                 job_push,
  output lcdws_pkg::desc_t     job
);
  import lcdws_pkg::*;

  logic [5:0] line_width_r;
  logic [5:0] line_width_nxt;
  logic [6:0] offset;
  logic [7:0] cursor_byte;

  always_comb begin
    line_width_nxt = cfg_we ? cfg_wdata : line_width_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
    end else begin
      line_width_r <= line_width_nxt;
    end
  end

  // lines 2 and 3 continue past the end of lines 0 and 1
  always_comb begin
    offset = {1'b0, req_column} + (req_line[1] ? {1'b0, line_width_r} : 7'd0);
    cursor_byte = CMD_DDRAM | (req_line[0] ? ROW_LINE_ODD : 8'h00) | {1'b0, offset};
  end

  always_comb begin
    job_push    = 1'b0;
    job.kind    = KIND_CMD;
    job.byte_a  = req_value;
    job.byte_b  = req_value;
    job.glyph   = req_glyph;
    unique case (req_op)
      OP_INIT: begin
        job_push   = req_valid;
        job.kind   = KIND_INIT;
        job.byte_a = (line_width_r > 6'd1) ? CMD_FUNC_2LINE : CMD_FUNC_1LINE;
      end
      OP_CHAR: begin
        job_push = req_valid;
        job.kind = KIND_DATA;
      end
      OP_CMD: begin
        job_push = req_valid;
        job.kind = KIND_CMD;
      end
      OP_CURSOR: begin
        job_push   = req_valid;
        job.kind   = KIND_CMD;
        job.byte_a = cursor_byte;
      end
      OP_HEX: begin
        job_push   = req_valid;
        job.kind   = KIND_HEX;
        job.byte_a = hex_char(req_value[7:4]);
        job.byte_b = hex_char(req_value[3:0]);
      end
      OP_GLYPH: begin
        job_push   = req_valid;
        job.kind   = KIND_GLYPH;
        job.byte_a = CMD_CGRAM | {2'b00, req_glyph, 3'b000};
      end
      // unknown opcodes are taken and dropped
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/lcdws_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
module lcdws_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcdws_pkg::desc_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output lcdws_pkg::desc_t head
);
  import lcdws_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == (AW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (do_push ? (AW+1)'(1) : '0) - (do_pop ? (AW+1)'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/lcdws_back.sv
// back end: steps through a job into the output register, one strobe per cycle while that register is free or popped
`timescale 1ns / 1ps
module lcdws_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  lcdws_pkg::desc_t job,
  output logic             job_done,
  input  logic             out_pop,
  output logic             out_empty,
  output logic             out_rs,
  output logic [3:0]       out_nibble,
  output logic [16:0]      out_wait_before_us,
  output logic [12:0]      out_wait_after_us,
  output logic             out_last
);
  import lcdws_pkg::*;

  logic [4:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic        rs_r;
  logic [3:0]  nibble_r;
  logic [16:0] before_r;
  logic [12:0] after_r;
  logic        last_r;

  logic        fire;
  logic        s_rs, s_last;
  logic [3:0]  s_nibble;
  logic [16:0] s_before;
  logic [12:0] s_after;
  logic [7:0]  s_byte;
  logic [12:0] lo_after;
  logic [4:0]  rel;
  logic [2:0]  idx;
  logic [3:0]  fill_sum;

  // step through the job; a strobe is made whenever the output register frees up
  assign fire     = job_valid && (!valid_r || out_pop);
  assign job_done = fire && s_last;

  always_comb begin
    s_rs     = 1'b0;
    s_byte   = job.byte_a;
    lo_after = T_CMD_LO;
    s_before = T_SETUP;
    s_last   = 1'b0;
    rel      = 5'd0;
    idx      = 3'd0;
    fill_sum = 4'd0;
    s_nibble = 4'd0;
    s_after  = T_HOLD;
    unique case (job.kind)
      KIND_DATA: begin
        s_rs     = 1'b1;
        lo_after = T_DATA_LO;
        s_last   = (step_r == LAST_BYTE);
      end
      KIND_CMD: begin
        s_last = (step_r == LAST_BYTE);
      end
      KIND_HEX: begin
        s_rs     = 1'b1;
        lo_after = T_DATA_LO;
        s_byte   = step_r[1] ? job.byte_b : job.byte_a;
        s_last   = (step_r == LAST_HEX);
      end
      KIND_GLYPH: begin
        s_last = (step_r == LAST_GLYPH);
        if (step_r >= 5'd2) begin
          rel      = step_r - 5'd2;
          idx      = rel[3:1];
          // row k is full once k reaches 7 - glyph
          fill_sum = {1'b0, idx} + {1'b0, job.glyph};
          s_rs     = 1'b1;
          lo_after = T_DATA_LO;
          s_byte   = (fill_sum >= 4'd7) ? ROW_FULL : ROW_BLANK;
        end
      end
      KIND_INIT: begin
        s_last = (step_r == LAST_INIT);
        if (step_r >= 5'd4) begin
          rel = step_r - 5'd4;
          idx = rel[3:1];
          case (idx)
            3'd0:    begin s_byte = job.byte_a;     lo_after = T_CMD_INIT_LO; end
            3'd1:    begin s_byte = CMD_ENTRY_MODE; lo_after = T_CMD_INIT_LO; end
            3'd2:    begin s_byte = CMD_CLEAR;      lo_after = T_CLEAR_LO;    end
            3'd3:    begin s_byte = CMD_DISP_ON;    lo_after = T_CMD_INIT_LO; end
            default: begin s_byte = CMD_DDRAM;      lo_after = T_CMD_LO;      end
          endcase
        end
      end
      default: begin
        s_last = 1'b1;
      end
    endcase

    s_nibble = step_r[0] ? s_byte[3:0] : s_byte[7:4];
    s_after  = step_r[0] ? lo_after : T_HOLD;

    // the four mode nibbles at the start of init
    if (job.kind == KIND_INIT && step_r < 5'd4) begin
      s_nibble = (step_r == 5'd3) ? NIB_INIT_4BIT : NIB_INIT_8BIT;
      s_after  = T_INIT_NIB;
      s_before = (step_r == 5'd0) ? T_POWERUP_SETUP : T_SETUP;
    end
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (out_pop) begin
      valid_nxt = 1'b0;
    end
    if (fire) begin
      valid_nxt = 1'b1;
      step_nxt  = s_last ? 5'd0 : step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 5'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rs_r     <= s_rs;
      nibble_r <= s_nibble;
      before_r <= s_before;
      after_r  <= s_after;
      last_r   <= s_last;
    end
  end

  assign out_empty          = !valid_r;
  assign out_rs             = rs_r;
  assign out_nibble         = nibble_r;
  assign out_wait_before_us = before_r;
  assign out_wait_after_us  = after_r;
  assign out_last           = last_r;

endmodule

FILE: src/char_lcd_4bit_write_sequencer_top.sv
// top level of the 4-bit character lcd write sequencer
//
//   channel  ports                                             transfer when
//   in       in_op in_value in_line in_column in_glyph_index   in_push && !in_full
//   out      out_rs out_nibble out_wait_before_us
//            out_wait_after_us out_last                        out_pop && !out_empty
//   cfg      cfg_we cfg_wdata (line width)                     cfg_we
//
// one strobe leaves the back end per cycle unless the output stalls; a request makes 2 to 18 strobes
// (init 14, character/command/cursor 2, hex 4, glyph 18), set by the step counter
// a request is taken in any cycle the two-entry job queue has room
// a stalled output holds its register and freezes the step counter only
// synchronous active-low reset empties the queue and sets line width to 16
`timescale 1ns / 1ps
module char_lcd_4bit_write_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_value,
  input  logic [1:0]  in_line,
  input  logic [5:0]  in_column,
  input  logic [2:0]  in_glyph_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_rs,
  output logic [3:0]  out_nibble,
  output logic [16:0] out_wait_before_us,
  output logic [12:0] out_wait_after_us,
  output logic        out_last
);
  import lcdws_pkg::*;

  logic  job_push;
  desc_t job_in;
  logic  q_full;
  logic  head_valid;
  desc_t head;
  logic  job_done;

  assign in_full = q_full;

  lcdws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (in_push && !q_full),
    .req_op     (in_op),
    .req_value  (in_value),
    .req_line   (in_line),
    .req_column (in_column),
    .req_glyph  (in_glyph_index),
    .job_push   (job_push),
    .job        (job_in)
  );

  lcdws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_in),
    .full       (q_full),
    .pop        (job_done),
    .head_valid (head_valid),
    .head       (head)
  );

  lcdws_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (head_valid),
    .job                (head),
    .job_done           (job_done),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_rs             (out_rs),
    .out_nibble         (out_nibble),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

endmodule
